>>> rtl/rfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfq_pkg
// Shared types, request and status codes, and defaults for the rotating queue.
// ----------------------------------------------------------------------------
package rfq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed port field widths
    localparam int REQ_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STEPS_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // magnitude bits of a positive step count
    localparam int DIVIDEND_W = STEPS_W - 1;

    localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ROT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOD,
        S_COPY,
        S_FRONT,
        S_DONE
    } rfq_state_t;

endpackage

>>> rtl/rfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rfq_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfq_mod
// Restoring remainder unit: step count modulo entry count, one bit per cycle.
// ----------------------------------------------------------------------------
module rfq_mod
    import rfq_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [CNT_W-1:0]      divisor,
    output logic                  done,
    output logic [CNT_W-1:0]      remainder
);

    localparam int ITER_W = $clog2(DIVIDEND_W);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]      dvs_reg, dvs_next;
    logic [CNT_W:0]        rem_reg, rem_next;
    logic [CNT_W:0]        trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[CNT_W-1:0], dvd_reg[DIVIDEND_W-1]};
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
            end else begin
                rem_next = trial;
            end
            dvd_next  = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_ITER) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        iter_reg <= iter_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[CNT_W-1:0];

endmodule

>>> rtl/rotating_fifo_queue_core.sv
`timescale 1ns / 1ps
// enqueue, dequeue and no-op rotate pass through the execute, front-read and done states
// rotate with positive steps adds the bit-serial modulo, plus a copy pass of k entries
// when k = steps mod count is nonzero, one ring copy per cycle through the write port
// one request in flight, a new one accepted only back in idle, even while a result waits
// aresetn (synchronous, active low) empties the queue; ring contents are not cleared
// ----------------------------------------------------------------------------
// rotating_fifo_queue_core
// FIFO queue on a ring RAM with enqueue, dequeue and rotate requests.
// ----------------------------------------------------------------------------
module rotating_fifo_queue_core
    import rfq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [REQ_W-1:0]           s_req_type,
    input  logic signed [DATA_W-1:0]   s_value,
    input  logic signed [STEPS_W-1:0]  s_rotate_steps,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_front_value,
    output logic                       m_front_valid,
    output logic [COUNT_W-1:0]         m_entry_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rfq_state_t state_reg, state_next;

    logic [REQ_W-1:0]       req_reg, req_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [STEPS_W-1:0]     steps_reg, steps_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic                   pend_reg, pend_next;

    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [DATA_W-1:0]      m_front_value_reg, m_front_value_next;
    logic                   m_front_valid_reg, m_front_valid_next;
    logic [COUNT_W-1:0]     m_entry_count_reg, m_entry_count_next;

    logic                   ram_we, ram_re;
    logic [PTR_W-1:0]       ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    logic                   div_start, div_done;
    logic [CNT_W-1:0]       div_rem;

    logic                   steps_pos, out_free;
    logic [VALUE_WIDTH+DATA_W-1:0]  in_wide, out_wide;
    logic [CNT_W+COUNT_W-1:0]       cnt_wide;

    rfq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rfq_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (steps_reg[DIVIDEND_W-1:0]),
        .divisor   (cnt_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign steps_pos = (steps_reg != '0) && !steps_reg[STEPS_W-1];
    assign out_free  = !m_valid_reg || m_ready;
    assign in_wide   = {{VALUE_WIDTH{1'b0}}, s_value};
    assign out_wide  = {{DATA_W{1'b0}}, ram_rdata};
    assign cnt_wide  = {{COUNT_W{1'b0}}, cnt_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (req_reg == REQ_ROT && cnt_reg != '0 && steps_pos) begin
                    state_next = S_MOD;
                end else begin
                    state_next = S_FRONT;
                end
            end
            S_MOD: begin
                if (div_done) begin
                    state_next = (div_rem == '0) ? S_FRONT : S_COPY;
                end
            end
            S_COPY: begin
                if (left_reg == '0 && !pend_reg) begin
                    state_next = S_FRONT;
                end
            end
            S_FRONT: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        req_next           = req_reg;
        val_next           = val_reg;
        steps_next         = steps_reg;
        status_next        = status_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        cnt_next           = cnt_reg;
        left_next          = left_reg;
        pend_next          = pend_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_front_value_next = m_front_value_reg;
        m_front_valid_next = m_front_valid_reg;
        m_entry_count_next = m_entry_count_reg;
        ram_we             = 1'b0;
        ram_waddr          = tail_reg;
        ram_wdata          = val_reg;
        ram_re             = 1'b0;
        ram_raddr          = head_reg;
        div_start          = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    val_next    = in_wide[VALUE_WIDTH-1:0];
                    steps_next  = s_rotate_steps;
                    status_next = ST_DONE;
                end
            end
            S_EXEC: begin
                case (req_reg)
                    REQ_ENQ: begin
                        if (cnt_reg == FULL_CNT) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            tail_next = ptr_inc(tail_reg);
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end
                    REQ_DEQ: begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            head_next = ptr_inc(head_reg);
                            cnt_next  = cnt_reg - 1'b1;
                        end
                    end
                    REQ_ROT: begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (steps_pos) begin
                            div_start = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MOD: begin
                if (div_done) begin
                    left_next = div_rem;
                    pend_next = 1'b0;
                end
            end
            S_COPY: begin
                // the write at tail takes the word read from head in the cycle before
                if (left_reg != '0) begin
                    ram_re    = 1'b1;
                    head_next = ptr_inc(head_reg);
                    left_next = left_reg - 1'b1;
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    tail_next = ptr_inc(tail_reg);
                end
                pend_next = (left_reg != '0);
            end
            S_FRONT: begin
                ram_re = 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = status_reg;
                    m_front_valid_next = (cnt_reg != '0);
                    m_front_value_next = (cnt_reg != '0) ? out_wide[DATA_W-1:0] : '0;
                    m_entry_count_next = cnt_wide[COUNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg           <= req_next;
        val_reg           <= val_next;
        steps_reg         <= steps_next;
        status_reg        <= status_next;
        left_reg          <= left_next;
        m_status_reg      <= m_status_next;
        m_front_value_reg <= m_front_value_next;
        m_front_valid_reg <= m_front_valid_next;
        m_entry_count_reg <= m_entry_count_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_front_value = m_front_value_reg;
    assign m_front_valid = m_front_valid_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

>>> rtl/rfq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfq_checker
// Port-level checks on the rotating queue results, bound to the top level.
// ----------------------------------------------------------------------------
module rfq_checker
    import rfq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [REQ_W-1:0]          s_req_type,
    input logic signed [DATA_W-1:0]  s_value,
    input logic signed [STEPS_W-1:0] s_rotate_steps,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [STATUS_W-1:0]       m_status,
    input logic signed [DATA_W-1:0]  m_front_value,
    input logic                      m_front_valid,
    input logic [COUNT_W-1:0]        m_entry_count
);

    localparam logic [COUNT_W+15:0] DEPTH_CNT = (COUNT_W + 16)'(DEPTH);

    logic [COUNT_W+15:0] count_wide;
    assign count_wide = {16'b0, m_entry_count};

    // front flag tracks the entry count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_front_valid == (m_entry_count != '0)))
        else $error("front_valid disagrees with entry_count");

    // an empty queue shows a zero front
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_front_valid) |-> (m_front_value == '0))
        else $error("nonzero front value on empty queue");

    // a dropped enqueue only happens on a full ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (count_wide == DEPTH_CNT))
        else $error("full status with ring not full");

    // a stalled result transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) &&
            $stable(m_front_value) && $stable(m_front_valid) && $stable(m_entry_count)))
        else $error("result changed while stalled");

    // a waiting request transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_req_type) &&
            $stable(s_value) && $stable(s_rotate_steps)))
        else $error("request changed while waiting");

endmodule

bind rotating_fifo_queue_core rfq_checker #(.DEPTH(DEPTH)) u_rfq_checker (.*);

>>> dv/tb_rotating_fifo_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotating_fifo_queue_core
// Self-checking bench for the rotating queue: a directed opening, then phases of
// random fill, drain and rotate traffic with bursty idling on both channels.
// Every response is checked against a cycle-free model of the ring.
// ----------------------------------------------------------------------------
module tb_rotating_fifo_queue_core;
    import rfq_pkg::*;

    localparam int                 RING_DEPTH    = DEPTH_DEF;
    localparam int                 PTR_W         = $clog2(RING_DEPTH);
    localparam logic [REQ_W-1:0]   REQ_NOP       = 2'd3;
    localparam int                 RANDOM_ITEMS  = 1700;
    localparam int                 QUIET_TAIL    = 150;
    localparam int                 STALL_LIMIT   = 3000;
    localparam int                 DRAIN_CYCLES  = 60;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic signed [DATA_W-1:0]  value;
        logic signed [STEPS_W-1:0] steps;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [DATA_W-1:0]  front;
        logic                      front_ok;
        logic [COUNT_W-1:0]        count;
    } response_t;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [REQ_W-1:0]          s_req_type     = '0;
    logic signed [DATA_W-1:0]  s_value        = '0;
    logic signed [STEPS_W-1:0] s_rotate_steps = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [STATUS_W-1:0]       m_status;
    logic signed [DATA_W-1:0]  m_front_value;
    logic                      m_front_valid;
    logic [COUNT_W-1:0]        m_entry_count;

    // queue model state
    logic signed [DATA_W-1:0]  ring_copy [RING_DEPTH];
    logic [PTR_W-1:0]          head_idx;
    logic [PTR_W-1:0]          tail_idx;
    int unsigned               held;

    request_t                  request_backlog [$];
    response_t                 pending_responses [$];
    bit                        in_fire;
    int                        gap_left;
    int                        stall_left;
    int                        error_count;
    int                        idle_cycles;

    rotating_fifo_queue_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_value        (s_value),
        .s_rotate_steps (s_rotate_steps),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_front_value  (m_front_value),
        .m_front_valid  (m_front_valid),
        .m_entry_count  (m_entry_count)
    );

    always #5 aclk = ~aclk;

    // applies one request to the model ring and returns the response it gives
    function automatic response_t predict_queue_response(request_t rq);
        response_t   rsp;
        int unsigned turns;
        rsp.status = ST_DONE;
        case (rq.kind)
            REQ_ENQ: begin
                if (held >= RING_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    ring_copy[tail_idx] = rq.value;
                    tail_idx = tail_idx + 1'b1;
                    held++;
                end
            end
            REQ_DEQ: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    head_idx = head_idx + 1'b1;
                    held--;
                end
            end
            REQ_ROT: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (rq.steps > 0) begin
                    turns = int'(rq.steps) % held;
                    for (int i = 0; i < turns; i++) begin
                        ring_copy[tail_idx] = ring_copy[head_idx];
                        tail_idx = tail_idx + 1'b1;
                        head_idx = head_idx + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        rsp.front_ok = (held != 0);
        rsp.front    = (held != 0) ? ring_copy[head_idx] : '0;
        rsp.count    = held[COUNT_W-1:0];
        return rsp;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %08h expected %08h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_request(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] value,
                               logic [STEPS_W-1:0] steps);
        request_t rq;
        rq.kind  = kind;
        rq.value = value;
        rq.steps = steps;
        request_backlog.push_back(rq);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] corners [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        if ($urandom_range(0, 99) < 15) begin
            return corners[$urandom_range(0, 3)];
        end
        return $urandom();
    endfunction

    function automatic logic [STEPS_W-1:0] pick_steps();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return STEPS_W'($urandom_range(1, 40));
        end else if (roll < 75) begin
            return STEPS_W'($urandom());
        end else if (roll < 85) begin
            return ($urandom_range(0, 1) == 0) ? '0 : STEPS_W'(-$urandom_range(1, 32768));
        end
        return STEPS_W'($urandom_range(1, 32767));
    endfunction

    // idling only away from the quiet windows and the tail of the run
    function automatic bit idling_allowed();
        int left;
        left = request_backlog.size();
        return (left > QUIET_TAIL) && ((left / 200) % 3 != 1);
    endfunction

    // request driver
    always @(negedge aclk) begin
        request_t rq;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else if (!(s_valid && !in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (request_backlog.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 5);
                s_valid <= 1'b0;
            end else begin
                rq = request_backlog.pop_front();
                s_req_type     <= rq.kind;
                s_value        <= rq.value;
                s_rotate_steps <= rq.steps;
                s_valid        <= 1'b1;
            end
        end
    end

    // response back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted request, check each accepted response
    always @(posedge aclk) begin
        request_t  seen;
        response_t want;
        in_fire = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                in_fire    = 1'b1;
                seen.kind  = s_req_type;
                seen.value = s_value;
                seen.steps = s_rotate_steps;
                pending_responses.push_back(predict_queue_response(seen));
            end
            if (m_valid && m_ready) begin
                if (pending_responses.size() == 0) begin
                    flag_mismatch("unexpected response", 32'(m_entry_count), 32'd0);
                end else begin
                    want = pending_responses.pop_front();
                    if (m_status !== want.status)
                        flag_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_front_value !== want.front)
                        flag_mismatch("front_value", m_front_value, want.front);
                    if (m_front_valid !== want.front_ok)
                        flag_mismatch("front_valid", 32'(m_front_valid), 32'(want.front_ok));
                    if (m_entry_count !== want.count)
                        flag_mismatch("entry_count", 32'(m_entry_count), 32'(want.count));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int phase_len;
        int roll;
        int enq_cut;
        int deq_cut;
        int rot_cut;
        int queued;

        error_count = 0;
        idle_cycles = 0;
        head_idx    = '0;
        tail_idx    = '0;
        held        = 0;

        // empty queue corners
        add_request(REQ_DEQ, $urandom(), STEPS_W'($urandom()));
        add_request(REQ_ROT, $urandom(), 16'd5);
        add_request(REQ_NOP, $urandom(), STEPS_W'($urandom()));
        // value extremes
        add_request(REQ_ENQ, 32'h8000_0000, STEPS_W'($urandom()));
        add_request(REQ_ENQ, 32'h7FFF_FFFF, STEPS_W'($urandom()));
        add_request(REQ_ENQ, 32'h0, STEPS_W'($urandom()));
        add_request(REQ_ENQ, 32'hFFFF_FFFF, STEPS_W'($urandom()));
        // rotates that leave the order alone
        add_request(REQ_ROT, $urandom(), 16'd0);
        add_request(REQ_ROT, $urandom(), 16'h8000);
        add_request(REQ_ROT, $urandom(), 16'hFFFF);
        add_request(REQ_ROT, $urandom(), 16'd8);
        // largest step count, then a single step
        add_request(REQ_ROT, $urandom(), 16'h7FFF);
        add_request(REQ_ROT, $urandom(), 16'd1);
        add_request(REQ_NOP, $urandom(), STEPS_W'($urandom()));
        repeat (4) add_request(REQ_DEQ, $urandom(), STEPS_W'($urandom()));
        add_request(REQ_DEQ, $urandom(), STEPS_W'($urandom()));
        add_request(REQ_ENQ, 32'h5A5A_A5A5, STEPS_W'($urandom()));
        add_request(REQ_ROT, $urandom(), 16'd3);
        add_request(REQ_DEQ, $urandom(), STEPS_W'($urandom()));

        // random phases biased toward filling, draining or rotating
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            mode      = $urandom_range(0, 3);
            phase_len = $urandom_range(20, 80);
            case (mode)
                0:       begin enq_cut = 75; deq_cut = 85; rot_cut = 97; end
                1:       begin enq_cut = 15; deq_cut = 85; rot_cut = 97; end
                2:       begin enq_cut = 40; deq_cut = 70; rot_cut = 97; end
                default: begin enq_cut = 35; deq_cut = 50; rot_cut = 97; end
            endcase
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < enq_cut)
                    add_request(REQ_ENQ, pick_value(), pick_steps());
                else if (roll < deq_cut)
                    add_request(REQ_DEQ, pick_value(), pick_steps());
                else if (roll < rot_cut)
                    add_request(REQ_ROT, pick_value(), pick_steps());
                else
                    add_request(REQ_NOP, pick_value(), pick_steps());
                queued++;
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (request_backlog.size() != 0 || s_valid || pending_responses.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_responses.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (pending_responses.size() != 0)
                flag_mismatch("responses never delivered", pending_responses.size(), 0);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rfq_pkg.sv
rtl/rfq_ram.sv
rtl/rfq_mod.sv
rtl/rotating_fifo_queue_core.sv
rtl/rfq_checker.sv
dv/tb_rotating_fifo_queue_core.sv
